// ----- rtl/core/dfs_pkg.sv -----
package dfs_pkg;

    localparam logic [1:0] CMD_LOAD_OFFSET = 2'd0;
    localparam logic [1:0] CMD_LOAD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_RUN         = 2'd2;
    localparam logic [1:0] CMD_READ        = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_DONE  = 2'd2;

    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GREY  = 2'd1;
    localparam logic [1:0] COLOR_BLACK = 2'd2;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 12;
    localparam int VALUE_W  = 13;
    localparam int TIME_W   = 12;
    localparam int STATUS_W = 2;

    localparam logic [0:0] REG_VERTEX_COUNT  = 1'd0;
    localparam logic [0:0] REG_SOURCE_VERTEX = 1'd1;

endpackage

// ----- rtl/core/dfs_ram.sv -----
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dfs_seq.sv -----
module dfs_seq
    import dfs_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [10:0]         i_vertex_count,
    input  logic [9:0]          i_source_vertex,
    output logic                o_done,
    output logic [TIME_W-1:0]   o_time,
    output logic [STATUS_W-1:0] o_status
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int OW = $clog2(MAX_VERTICES + 1);
    localparam int CW = EW + 1;
    localparam int NW = VW + 1;
    localparam int MW = (CW > 32) ? CW : 32;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_DISC  = 4'd3;
    localparam logic [3:0] S_DISCW = 4'd4;
    localparam logic [3:0] S_TOP   = 4'd5;
    localparam logic [3:0] S_TOPW  = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_EDGE  = 4'd8;
    localparam logic [3:0] S_COLR  = 4'd9;
    localparam logic [3:0] S_SWEEP = 4'd10;
    localparam logic [3:0] S_SWW   = 4'd11;
    localparam logic [3:0] S_READ  = 4'd12;
    localparam logic [3:0] S_READW = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [NW-1:0]     r_n;
    logic [VW-1:0]     r_v;
    logic [NW-1:0]     r_sweep;
    logic [NW-1:0]     r_sp;
    logic [TIME_W-1:0] r_clock;
    logic [CW-1:0]     r_cur;
    logic [VW:0]       r_clr;
    logic              r_phase;
    logic              r_ran;
    logic [TIME_W-1:0] r_time;
    logic [STATUS_W-1:0] r_status;

    logic              off_we;
    logic [OW-1:0]     off_wa, off_ra;
    logic [VALUE_W-1:0] off_rd;
    logic              edg_we;
    logic [EW-1:0]     edg_wa, edg_ra;
    logic [9:0]        edg_rd;
    logic              col_we;
    logic [VW-1:0]     col_wa, col_ra;
    logic [1:0]        col_wd, col_rd;
    logic              tim_we;
    logic [VW-1:0]     tim_wa, tim_ra;
    logic [TIME_W-1:0] tim_wd, tim_rd;
    logic              stk_we;
    logic [VW-1:0]     stk_wa, stk_ra;
    logic [VW+CW-1:0]  stk_wd, stk_rd;

    logic [MW-1:0]     off_ext;
    logic [CW-1:0]     off_cap;
    logic [VW-1:0]     top_v;
    logic [CW-1:0]     top_cur;

    dfs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_VERTICES + 1)) u_off (
        .i_clk, .i_we(off_we), .i_waddr(off_wa), .i_wdata(i_value),
        .i_raddr(off_ra), .o_rdata(off_rd));
    dfs_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_edge (
        .i_clk, .i_we(edg_we), .i_waddr(edg_wa), .i_wdata(i_value[9:0]),
        .i_raddr(edg_ra), .o_rdata(edg_rd));
    dfs_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_color (
        .i_clk, .i_we(col_we), .i_waddr(col_wa), .i_wdata(col_wd),
        .i_raddr(col_ra), .o_rdata(col_rd));
    dfs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_time (
        .i_clk, .i_we(tim_we), .i_waddr(tim_wa), .i_wdata(tim_wd),
        .i_raddr(tim_ra), .o_rdata(tim_rd));
    dfs_ram #(.WIDTH(VW + CW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk, .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    assign off_ext = MW'(off_rd);
    assign off_cap = (off_ext > MW'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(off_rd);
    assign top_v   = stk_rd[VW+CW-1:CW];
    assign top_cur = stk_rd[CW-1:0];

    always_comb begin
        n_state = r_state;
        off_we = 1'b0; off_wa = i_addr[OW-1:0]; off_ra = OW'(r_v);
        edg_we = 1'b0; edg_wa = i_addr[EW-1:0]; edg_ra = r_cur[EW-1:0];
        col_we = 1'b0; col_wa = r_v; col_wd = COLOR_WHITE; col_ra = r_v;
        tim_we = 1'b0; tim_wa = r_v; tim_wd = '1; tim_ra = i_addr[VW-1:0];
        stk_we = 1'b0; stk_wa = r_sp[VW-1:0]; stk_wd = {r_v, r_cur};
        stk_ra = VW'(r_sp - NW'(1));
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_LOAD_OFFSET: off_we = (32'(i_addr) <= MAX_VERTICES);
                        CMD_LOAD_EDGE: edg_we = (32'(i_addr) < MAX_EDGES)
                                                && (32'(i_value) < MAX_VERTICES);
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                col_we = 1'b1; col_wa = r_clr[VW-1:0]; col_wd = COLOR_WHITE;
                tim_we = 1'b1; tim_wa = r_clr[VW-1:0]; tim_wd = '1;
            end
            S_DISC: begin
                tim_we = 1'b1; tim_wd = r_clock + TIME_W'(1);
                col_we = 1'b1; col_wd = COLOR_GREY;
            end
            S_DISCW: begin
                stk_we = 1'b1; stk_wd = {r_v, CW'(off_rd)};
            end
            S_END: begin
                if (!r_phase) begin
                    off_ra = OW'(r_v) + OW'(1);
                end else if (r_cur >= off_cap) begin
                    col_we = 1'b1; col_wd = COLOR_BLACK;
                end else begin
                    stk_we = 1'b1; stk_wa = VW'(r_sp - NW'(1));
                    stk_wd = {r_v, r_cur + CW'(1)};
                end
            end
            S_COLR: col_ra = edg_rd[VW-1:0];
            S_SWEEP: col_ra = r_sweep[VW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_ran <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_time <= '0;
                        case (i_cmd)
                            CMD_LOAD_OFFSET:
                                r_status <= (32'(i_addr) > MAX_VERTICES) ? STATUS_RANGE
                                                                         : STATUS_OK;
                            CMD_LOAD_EDGE:
                                r_status <= ((32'(i_addr) < MAX_EDGES)
                                             && (32'(i_value) < MAX_VERTICES)) ? STATUS_OK
                                                                               : STATUS_RANGE;
                            default: r_status <= STATUS_OK;
                        endcase
                        r_n <= (32'(i_vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                                    : NW'(i_vertex_count);
                        if (i_cmd == CMD_RUN) begin
                            r_state <= S_CLEAR;
                            r_clr <= '0;
                            r_ran <= 1'b1;
                        end else if (i_cmd == CMD_READ) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ: r_state <= S_READW;
                S_READW: begin
                    if (32'(i_addr) < 32'(r_n)) r_time <= r_ran ? tim_rd : '1;
                    else r_status <= STATUS_RANGE;
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == MAX_VERTICES - 1) begin
                        r_clock <= '0;
                        r_sp <= '0;
                        r_sweep <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (32'(i_source_vertex) < 32'(r_n)) begin
                        r_v <= VW'(i_source_vertex);
                        r_state <= S_DISC;
                    end else begin
                        r_state <= S_SWEEP;
                    end
                end
                S_DISC: begin
                    r_clock <= r_clock + TIME_W'(1);
                    r_state <= S_DISCW;
                end
                S_DISCW: begin
                    r_sp <= r_sp + NW'(1);
                    r_state <= S_TOP;
                end
                S_TOP: begin
                    if (r_sp == '0) r_state <= S_SWEEP;
                    else r_state <= S_TOPW;
                end
                S_TOPW: begin
                    r_v <= top_v;
                    r_cur <= top_cur;
                    r_phase <= 1'b0;
                    r_state <= S_END;
                end
                S_END: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (r_cur >= off_cap) begin
                            r_sp <= r_sp - NW'(1);
                            r_state <= S_TOP;
                        end else begin
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_EDGE: r_state <= S_COLR;
                S_COLR: begin
                    r_v <= edg_rd[VW-1:0];
                    if (32'(edg_rd) < 32'(r_n)) begin
                        r_phase <= 1'b1;
                        r_state <= S_SWW;
                    end else begin
                        r_phase <= 1'b0;
                        r_state <= S_TOP;
                    end
                end
                S_SWEEP: begin
                    if (r_sweep >= r_n) begin
                        r_time <= r_clock;
                        r_status <= STATUS_DONE;
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_sweep[VW-1:0];
                        r_phase <= 1'b0;
                        r_state <= S_SWW;
                    end
                end
                S_SWW: begin
                    if (col_rd == COLOR_WHITE) r_state <= S_DISC;
                    else if (r_phase) r_state <= S_TOP;
                    else begin
                        r_sweep <= r_sweep + NW'(1);
                        r_state <= S_SWEEP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = (r_state == S_IDLE);
    assign o_time   = r_time;
    assign o_status = r_status;

endmodule

// ----- rtl/core/csr_dfs_discovery_times.sv -----
// Channel | Signals                               | Direction
// input   | i_valid/o_ready, i_cmd, i_addr, i_in_value | in
// result  | o_valid/i_ready, o_start_time, o_status     | out
// config  | psel/penable/pwrite/paddr/pwdata/prdata/pready | APB
// A run first clears every colour and time table entry, then walks the graph
// from the source and sweeps the remaining vertices; each table has one read port.
// Synchronous active-low reset; tables are not cleared by reset.
// One item at a time; the next item is taken the cycle after the result is accepted.
module csr_dfs_discovery_times
    import dfs_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [VALUE_W-1:0]  i_in_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [TIME_W-1:0] o_start_time,
    output logic [STATUS_W-1:0] o_status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [10:0]        r_vertex_count;
    logic [9:0]         r_source_vertex;
    logic               r_busy, r_ovalid;
    logic [CMD_W-1:0]   r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic [VALUE_W-1:0] r_value;
    logic [TIME_W-1:0]  r_time;
    logic [STATUS_W-1:0] r_status;
    logic               start, done;
    logic [TIME_W-1:0]  s_time;
    logic [STATUS_W-1:0] s_status;
    logic               r_go;

    assign pready  = 1'b1;
    assign o_ready = !r_busy;
    assign start   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= 11'd1;
            r_source_vertex <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_VERTEX_COUNT) r_vertex_count <= pwdata[10:0];
            else r_source_vertex <= pwdata[9:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(r_vertex_count)
                                                   : 32'(r_source_vertex);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovalid <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_go <= start;
            if (start) begin
                r_busy <= 1'b1;
                r_cmd <= i_cmd;
                r_addr <= i_addr;
                r_value <= i_in_value;
            end
            if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
                r_busy <= 1'b0;
            end
            if (r_busy && !r_go && !r_ovalid && done) begin
                r_ovalid <= 1'b1;
                r_time <= s_time;
                r_status <= s_status;
            end
        end
    end

    dfs_seq #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_seq (
        .i_clk, .i_rst_n, .i_start(r_go), .i_cmd(r_cmd), .i_addr(r_addr),
        .i_value(r_value), .i_vertex_count(r_vertex_count),
        .i_source_vertex(r_source_vertex), .o_done(done), .o_time(s_time),
        .o_status(s_status));

    assign o_valid      = r_ovalid;
    assign o_start_time = r_time;
    assign o_status     = r_status;

endmodule

// ----- sim/tb_csr_dfs_discovery_times.sv -----
module tb_csr_dfs_discovery_times;
    import dfs_pkg::*;

    localparam int NV       = 1024;
    localparam int NE       = 4096;
    localparam int WD_LIMIT = 200000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [ADDR_W-1:0]        addr;
        logic [VALUE_W-1:0]       val;
        bit                       typed;
        logic signed [TIME_W-1:0] t;
        logic [STATUS_W-1:0]      s;
    } row_t;

    typedef struct {
        logic signed [TIME_W-1:0] t;
        logic [STATUS_W-1:0]      s;
    } result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [CMD_W-1:0]         i_cmd = '0;
    logic [ADDR_W-1:0]        i_addr = '0;
    logic [VALUE_W-1:0]       i_in_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [TIME_W-1:0] o_start_time;
    logic [STATUS_W-1:0]      o_status;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    csr_dfs_discovery_times dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block
    int unsigned offs [0:NV];
    bit          offs_set [0:NV];
    int unsigned edges [0:NE-1];
    bit          edges_set [0:NE-1];
    logic [1:0]  color [0:NV-1];
    int          disc [0:NV-1];
    int unsigned stk_v [0:NV-1];
    int unsigned stk_c [0:NV-1];
    int unsigned depth, clk_count;
    int unsigned vcount = 1, source = 0;

    result_t     pending_q [$];
    row_t        rows [$];
    int          errors = 0;
    int          n_runs = 0, n_reads = 0, n_loads = 0, n_results = 0;
    int          idle_cycles = 0;
    bit          hold_req = 0;
    bit          tail = 0;

    function automatic int unsigned live_n();
        return (vcount > NV) ? NV : vcount;
    endfunction

    function automatic int unsigned edge_end(int unsigned v);
        return (offs[v+1] > NE) ? NE : offs[v+1];
    endfunction

    function automatic void discover(int unsigned v);
        clk_count++;
        disc[v] = clk_count;
        color[v] = COLOR_GREY;
        if (depth < NV) begin
            stk_v[depth] = v;
            stk_c[depth] = offs[v];
            depth++;
        end
    endfunction

    function automatic void walk(int unsigned root, int unsigned n);
        int unsigned u, cur, tgt;
        discover(root);
        while (depth > 0) begin
            u = stk_v[depth-1];
            cur = stk_c[depth-1];
            if (cur >= edge_end(u)) begin
                color[u] = COLOR_BLACK;
                depth--;
            end else begin
                stk_c[depth-1] = cur + 1;
                tgt = edges[cur];
                if (tgt < n && color[tgt] == COLOR_WHITE) discover(tgt);
            end
        end
    endfunction

    // a run may only touch table entries that were written
    function automatic bit run_legal();
        int unsigned n;
        n = live_n();
        for (int unsigned v = 0; v < n; v++) begin
            if (!offs_set[v] || !offs_set[v+1]) return 0;
            for (int unsigned e = offs[v]; e < edge_end(v); e++)
                if (!edges_set[e]) return 0;
        end
        return 1;
    endfunction

    function automatic result_t predict_dfs(logic [CMD_W-1:0] cmd, int unsigned addr,
                                            int unsigned val);
        result_t r;
        int unsigned n;
        r.t = '0;
        r.s = STATUS_OK;
        n = live_n();
        case (cmd)
            CMD_LOAD_OFFSET: begin
                if (addr <= NV) begin
                    offs[addr] = val;
                    offs_set[addr] = 1;
                end else r.s = STATUS_RANGE;
            end
            CMD_LOAD_EDGE: begin
                if (addr < NE && val < NV) begin
                    edges[addr] = val;
                    edges_set[addr] = 1;
                end else r.s = STATUS_RANGE;
            end
            CMD_RUN: begin
                for (int u = 0; u < NV; u++) begin
                    color[u] = COLOR_WHITE;
                    disc[u] = -1;
                end
                clk_count = 0;
                depth = 0;
                if (source < n) walk(source, n);
                for (int unsigned u = 0; u < n; u++)
                    if (color[u] == COLOR_WHITE) walk(u, n);
                r.t = clk_count;
                r.s = STATUS_DONE;
            end
            default: begin
                if (addr < n) r.t = disc[addr];
                else r.s = STATUS_RANGE;
            end
        endcase
        return r;
    endfunction

    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                             logic [VALUE_W-1:0] val, bit typed = 0,
                             logic signed [TIME_W-1:0] t = '0,
                             logic [STATUS_W-1:0] s = '0);
        result_t r;
        int gap;
        gap = (!tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd <= cmd;
        i_addr <= addr;
        i_in_value <= val;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        r = predict_dfs(cmd, addr, val);
        if (typed) begin
            r.t = t;
            r.s = s;
        end
        pending_q.push_back(r);
        case (cmd)
            CMD_RUN: n_runs++;
            CMD_READ: n_reads++;
            default: n_loads++;
        endcase
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        drop_valid();
        wait (pending_q.size() == 0);
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_VERTEX_COUNT) vcount = value & 32'h7FF;
        else source = value & 32'h3FF;
    endtask

    task automatic run_if_legal();
        if (run_legal()) send_item(CMD_RUN, $urandom, $urandom);
        else send_item(CMD_READ, $urandom_range(0, 4095), $urandom_range(0, 4096));
    endtask

    // graph of n vertices, then a run if every entry it needs is written, and some reads
    task automatic graph_sequence(int unsigned n);
        int unsigned cum, e, hi;
        cum = ($urandom_range(0, 9) == 0) ? 4080 + $urandom_range(0, 8) : $urandom_range(0, 4);
        hi = 0;
        for (int unsigned v = 0; v <= n; v++) begin
            if (v > 0) cum += $urandom_range(0, 3);
            if (v > 0 && $urandom_range(0, 19) == 0) begin
                send_item(CMD_LOAD_OFFSET, v, $urandom_range(0, 4096));
                send_item(CMD_LOAD_OFFSET, v, (cum > 4096) ? 4096 : cum);
            end else begin
                send_item(CMD_LOAD_OFFSET, v, cum);
            end
        end
        for (int unsigned v = 0; v < n; v++)
            if (edge_end(v) > hi) hi = edge_end(v);
        for (int unsigned i = offs[0]; i < hi; i++) begin
            if (edges_set[i] && $urandom_range(0, 1) == 0) continue;
            if ($urandom_range(0, 15) == 0)
                send_item(CMD_LOAD_EDGE, i, $urandom_range(NV, 4096));
            e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NV - 1)
                                            : $urandom_range(0, n - 1);
            send_item(CMD_LOAD_EDGE, i, e);
        end
        run_if_legal();
        repeat ($urandom_range(2, 8)) send_item(CMD_READ, $urandom_range(0, n + 1), $urandom);
    endtask

    always @(posedge i_clk) begin
        result_t x;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected item start_time=%0d status=%0d",
                         $time, o_start_time, o_status);
                errors++;
            end else begin
                x = pending_q.pop_front();
                if (o_start_time !== x.t) begin
                    $display("%0t: start_time expected %0d actual %0d",
                             $time, x.t, o_start_time);
                    errors++;
                end
                if (o_status !== x.s) begin
                    $display("%0t: status expected %0d actual %0d", $time, x.s, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb_csr_dfs_discovery_times: done, errors");
            $finish;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else if (tail) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned n, sent, base;
        bit held;
        held = 0;
        for (int u = 0; u < NV; u++) begin
            color[u] = COLOR_WHITE;
            disc[u] = -1;
        end
        depth = 0;
        clk_count = 0;

        rows.push_back('{CMD_READ, 0, 0, 1, -1, STATUS_OK});
        rows.push_back('{CMD_READ, 1, 0, 1, 0, STATUS_RANGE});
        rows.push_back('{CMD_READ, 4095, 8191, 1, 0, STATUS_RANGE});
        rows.push_back('{CMD_LOAD_OFFSET, 1025, 0, 1, 0, STATUS_RANGE});
        rows.push_back('{CMD_LOAD_OFFSET, 4095, 8191, 1, 0, STATUS_RANGE});
        rows.push_back('{CMD_LOAD_OFFSET, 0, 0, 1, 0, STATUS_OK});
        rows.push_back('{CMD_LOAD_OFFSET, 1, 1, 1, 0, STATUS_OK});
        rows.push_back('{CMD_LOAD_EDGE, 0, 1024, 1, 0, STATUS_RANGE});
        rows.push_back('{CMD_LOAD_EDGE, 4095, 8191, 1, 0, STATUS_RANGE});
        rows.push_back('{CMD_LOAD_EDGE, 0, 0, 1, 0, STATUS_OK});
        rows.push_back('{CMD_LOAD_EDGE, 4095, 1023, 1, 0, STATUS_OK});
        rows.push_back('{CMD_RUN, 0, 0, 1, 1, STATUS_DONE});
        rows.push_back('{CMD_READ, 0, 0, 1, 1, STATUS_OK});
        rows.push_back('{CMD_LOAD_OFFSET, 1024, 4096, 1, 0, STATUS_OK});
        rows.push_back('{CMD_LOAD_OFFSET, 0, 8191, 1, 0, STATUS_OK});
        rows.push_back('{CMD_RUN, 4095, 8191, 1, 1, STATUS_DONE});
        rows.push_back('{CMD_READ, 0, 0, 0, 0, 0});
        rows.push_back('{CMD_LOAD_EDGE, 1, 5, 0, 0, 0});
        rows.push_back('{CMD_LOAD_OFFSET, 0, 0, 0, 0, 0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_item(rows[k].cmd, rows[k].addr, rows[k].val, rows[k].typed,
                      rows[k].t, rows[k].s);

        // no vertices at all
        write_reg(REG_VERTEX_COUNT, 0);
        send_item(CMD_RUN, 0, 0, 1, 0, STATUS_DONE);
        send_item(CMD_READ, 0, 0, 1, 0, STATUS_RANGE);

        // largest graph: count capped, source at the top, random edges from the lowest vertices
        write_reg(REG_VERTEX_COUNT, 2047);
        write_reg(REG_SOURCE_VERTEX, 1023);
        for (int v = 0; v <= NV; v++) send_item(CMD_LOAD_OFFSET, v, (v < 16) ? v : 16);
        for (int i = 0; i < 16; i++) send_item(CMD_LOAD_EDGE, i, $urandom_range(0, NV - 1));
        send_item(CMD_RUN, 0, 0, 1, 1024, STATUS_DONE);
        send_item(CMD_READ, 1023, 0, 1, 1, STATUS_OK);
        send_item(CMD_READ, 1024, 0, 1, 0, STATUS_RANGE);
        send_item(CMD_READ, 0, 0);
        send_item(CMD_READ, 15, 0);

        // source outside the graph: only the sweep runs
        write_reg(REG_VERTEX_COUNT, 4);
        send_item(CMD_RUN, 0, 0, 1, 4, STATUS_DONE);
        send_item(CMD_READ, 0, 0);

        base = n_loads + n_runs + n_reads;
        sent = 0;
        while (sent < 450) begin
            if (sent > 380) tail = 1;
            if (!held && sent > 100) begin
                hold_req = 1;
                held = 1;
            end
            if ($urandom_range(0, 4) != 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                write_reg(REG_VERTEX_COUNT, n);
                write_reg(REG_SOURCE_VERTEX,
                          ($urandom_range(0, 5) == 0) ? $urandom_range(n, 1023)
                                                      : $urandom_range(0, n - 1));
                graph_sequence(n);
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(REG_SOURCE_VERTEX, $urandom_range(0, n));
                    run_if_legal();
                    send_item(CMD_READ, $urandom_range(0, n), 0);
                end
            end else begin
                repeat ($urandom_range(3, 12)) begin
                    case ($urandom_range(0, 3))
                        0: send_item(CMD_LOAD_OFFSET, $urandom, $urandom_range(0, 4096));
                        1: send_item(CMD_LOAD_EDGE, $urandom, $urandom_range(0, 4096));
                        2: run_if_legal();
                        default: send_item(CMD_READ, $urandom, $urandom);
                    endcase
                end
            end
            sent = n_loads + n_runs + n_reads - base;
        end

        drop_valid();
        wait (pending_q.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d loads, %0d runs, %0d reads; %0d results checked",
                 n_loads, n_runs, n_reads, n_results);
        if (errors == 0 && pending_q.size() == 0)
            $display("tb_csr_dfs_discovery_times: done, clean");
        else
            $display("tb_csr_dfs_discovery_times: done, errors");
        $finish;
    end

endmodule
